FILE: rtl/core/elevator_car_controller_top_defines.svh
// Assertion macros shared by the elevator car controller RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ELEVATOR_CAR_CONTROLLER_TOP_DEFINES_SVH
`define ELEVATOR_CAR_CONTROLLER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ecc_pkg.sv
// Package for the elevator car controller: beat types, codes and constants.
// No dependencies; every RTL module imports it.
`default_nettype none

package ecc_pkg;

  localparam int FLOOR_W   = 4;
  localparam int PEND_W    = 10;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] DOOR_TICKS_RST   = 16'd3000;
  localparam logic [CNT_W-1:0] TRAVEL_TICKS_RST = 16'd1000;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_FAULT   = 2'd2,
    KIND_REPAIR  = 2'd3
  } ecc_kind_t;

  typedef enum logic [1:0] {
    DIR_STATIC = 2'd0,
    DIR_UP     = 2'd1,
    DIR_DOWN   = 2'd2
  } ecc_dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOOR_OPEN_TICKS = 1'b0,
    CFG_TRAVEL_TICKS    = 1'b1
  } ecc_cfg_idx_t;

  typedef struct packed {
    ecc_kind_t          kind;
    logic [FLOOR_W-1:0] request_floor;
  } ecc_in_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] current_floor;
    logic [1:0]         direction;
    logic               door_open;
    logic               car_active;
    logic               car_moving;
    logic [PEND_W-1:0]  pending_floors;
    logic               under_maintenance;
    logic               status_publish;
  } ecc_out_t;

  // Scalar car state carried between the state registers and the pass logic.
  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic [FLOOR_W-1:0] target;
    ecc_dir_t           dir;
    logic               door_open;
    logic               active;
    logic               moving;
    logic               fault;
    logic               pend_pub;
    logic [CNT_W-1:0]   door_cnt;
    logic [CNT_W-1:0]   travel_cnt;
  } ecc_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ecc_in_stage.sv
// Input register of the elevator car controller: holds one accepted beat.
// Depends on ecc_pkg.
`default_nettype none

module ecc_in_stage
  import ecc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire ecc_in_t in_data,
  output logic         in_stall,
  input  wire logic    advance,
  output logic         s1_valid,
  output ecc_in_t      s1_data
);

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  ecc_in_t s1_data_r;
  logic    accept;

  // The held beat leaves whenever the pass logic takes it, so a new beat may
  // enter in the same cycle.
  assign in_stall     = s1_valid_r && !advance;
  assign accept       = in_valid && !in_stall;
  assign s1_valid_nxt = accept || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/ecc_pass.sv
// Combinational logic of one control-loop pass of the elevator car.
// Depends on ecc_pkg.
`default_nettype none

module ecc_pass
  import ecc_pkg::*;
#(
  parameter int NUM_FLOORS = 10
) (
  input  wire ecc_in_t                 item,
  input  wire ecc_ctrl_t               ctrl,
  input  wire logic [NUM_FLOORS-1:0]   mask,
  input  wire logic [CNT_W-1:0]        door_ticks,
  input  wire logic [CNT_W-1:0]        travel_ticks,
  output ecc_ctrl_t                    ctrl_nxt,
  output logic [NUM_FLOORS-1:0]        mask_nxt,
  output logic                         publish
);

  localparam logic [FLOOR_W:0] NF_L    = (FLOOR_W + 1)'(NUM_FLOORS);
  localparam logic [FLOOR_W:0] TOP_FLR = (FLOOR_W + 1)'(NUM_FLOORS - 1);

  ecc_ctrl_t             c;
  logic [NUM_FLOORS-1:0] m;
  logic                  pub;
  logic                  found;
  logic [FLOOR_W-1:0]    hit;

  always_comb begin
    c     = ctrl;
    m     = mask;
    pub   = 1'b0;
    found = 1'b0;
    hit   = ctrl.target;

    case (item.kind)
      KIND_REQUEST: begin
        if ({1'b0, item.request_floor} < NF_L) begin
          c.target   = item.request_floor;
          c.pend_pub = 1'b1;
          m          = m | (NUM_FLOORS'(1) << item.request_floor);
          if (item.request_floor > c.floor) begin
            c.dir = DIR_UP;
          end else if (item.request_floor < c.floor) begin
            c.dir = DIR_DOWN;
          end
        end
      end
      KIND_FAULT:  c.fault = 1'b1;
      KIND_REPAIR: c.fault = 1'b0;
      default: ;
    endcase

    if (!c.fault) begin
      if (c.pend_pub) begin
        c.pend_pub = 1'b0;
        pub        = 1'b1;
      end

      if (!c.active && (c.floor != c.target)) begin
        c.active   = 1'b1;
        c.dir      = (c.target > c.floor) ? DIR_UP : DIR_DOWN;
        c.moving   = 1'b1;
        c.pend_pub = 1'b1;
      end

      // Arrival: open the door, drop this floor's request and look for the
      // farthest pending floor further along the current direction.
      if (c.active && (c.floor == c.target) && !c.door_open) begin
        c.door_open = 1'b1;
        m           = m & ~(NUM_FLOORS'(1) << c.floor);
        c.pend_pub  = 1'b1;
        if (c.dir == DIR_UP) begin
          for (int i = 0; i < NUM_FLOORS; i++) begin
            if (m[i] && (FLOOR_W'(i) > c.floor)) begin
              found = 1'b1;
              hit   = FLOOR_W'(i);
            end
          end
        end else if (c.dir == DIR_DOWN) begin
          for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
            if (m[i] && (FLOOR_W'(i) < c.floor)) begin
              found = 1'b1;
              hit   = FLOOR_W'(i);
            end
          end
        end
        if (found) begin
          c.target = hit;
        end else begin
          c.active = 1'b0;
          if (c.dir != DIR_STATIC) begin
            c.dir = DIR_STATIC;
          end
        end
      end

      if (c.door_open) begin
        c.door_cnt = c.door_cnt + CNT_W'(1);
      end
      if (c.door_cnt >= door_ticks) begin
        c.door_cnt  = '0;
        c.pend_pub  = 1'b1;
        c.door_open = 1'b0;
        if (c.dir != DIR_STATIC) begin
          c.moving = 1'b1;
        end
      end

      if (c.moving) begin
        c.travel_cnt = c.travel_cnt + CNT_W'(1);
      end
      if (c.travel_cnt >= travel_ticks) begin
        c.travel_cnt = '0;
        c.pend_pub   = 1'b1;
        if (c.floor == c.target) begin
          c.moving = 1'b0;
        end
        if (c.dir == DIR_UP) begin
          if ({1'b0, c.floor} < TOP_FLR) begin
            c.floor = c.floor + FLOOR_W'(1);
          end
        end else if (c.dir == DIR_DOWN) begin
          if (c.floor != '0) begin
            c.floor = c.floor - FLOOR_W'(1);
          end
        end
      end
    end
  end

  assign ctrl_nxt = c;
  assign mask_nxt = m;
  assign publish  = pub;

endmodule

`default_nettype wire

FILE: rtl/core/ecc_state.sv
// Car state and limit registers of the elevator car controller, with the pass
// logic that updates them. Depends on ecc_pkg, ecc_pass and the defines header.
`default_nettype none
`include "elevator_car_controller_top_defines.svh"

module ecc_state
  import ecc_pkg::*;
#(
  parameter int NUM_FLOORS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_wdata,
  input  wire logic                 step_en,
  input  wire ecc_in_t              item,
  output ecc_out_t                  result_nxt
);

  localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(NUM_FLOORS - 1);

  ecc_ctrl_t             ctrl_r;
  ecc_ctrl_t             ctrl_nxt;
  logic [NUM_FLOORS-1:0] mask_r;
  logic [NUM_FLOORS-1:0] mask_nxt;
  logic [CNT_W-1:0]      door_ticks_r;
  logic [CNT_W-1:0]      travel_ticks_r;
  logic                  publish;
  logic                  fault_pass;

  ecc_pass #(
    .NUM_FLOORS (NUM_FLOORS)
  ) u_pass (
    .item         (item),
    .ctrl         (ctrl_r),
    .mask         (mask_r),
    .door_ticks   (door_ticks_r),
    .travel_ticks (travel_ticks_r),
    .ctrl_nxt     (ctrl_nxt),
    .mask_nxt     (mask_nxt),
    .publish      (publish)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_ticks_r   <= DOOR_TICKS_RST;
      travel_ticks_r <= TRAVEL_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOOR_OPEN_TICKS: door_ticks_r   <= cfg_wdata;
        CFG_TRAVEL_TICKS:    travel_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '{floor: '0, target: '0, dir: DIR_STATIC, door_open: 1'b0,
                 active: 1'b0, moving: 1'b0, fault: 1'b0, pend_pub: 1'b0,
                 door_cnt: '0, travel_cnt: '0};
      mask_r <= '0;
    end else if (step_en) begin
      ctrl_r <= ctrl_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_comb begin
    result_nxt.current_floor     = ctrl_nxt.floor;
    result_nxt.direction         = 2'(ctrl_nxt.dir);
    result_nxt.door_open         = ctrl_nxt.door_open;
    result_nxt.car_active        = ctrl_nxt.active;
    result_nxt.car_moving        = ctrl_nxt.moving;
    result_nxt.pending_floors    = PEND_W'(mask_nxt);
    result_nxt.under_maintenance = ctrl_nxt.fault;
    result_nxt.status_publish    = publish;
  end

  assign fault_pass = step_en && ctrl_nxt.fault;

  `ECC_ASSERT_NOW(a_floor_in_range, 1'b1, ctrl_r.floor <= TOP_FLOOR, "car floor out of range")
  `ECC_ASSERT_NOW(a_active_has_dir, ctrl_r.active, ctrl_r.dir != DIR_STATIC, "active car static")
  `ECC_ASSERT_NEXT(a_fault_holds_floor, fault_pass, $stable(ctrl_r.floor), "floor moved in fault")

endmodule

`default_nettype wire

FILE: rtl/core/elevator_car_controller_top.sv
// Top level of the elevator car controller: input register, car state with its
// pass logic, and the result register. Depends on ecc_pkg, ecc_in_stage, ecc_state.
//
// How to use this block:
// Each input beat on in_data is one control-loop pass of a single car. Its kind
// field says whether the pass is a plain tick, a floor request, a fault report
// or a repair report; request_floor is only looked at for a request.
// Every pass produces exactly one result beat on out_data, showing the car's
// state once the pass has been applied, plus a flag for a status publication.
// The input beat is captured in an input register; once the result register is free, the pass
// logic updates the car state from it and loads the result register. One beat is taken every
// cycle while results drain, since the pass between the two registers is combinational.
// While out_stall is high and a result waits, it holds still and no pass is taken; in_stall
// rises in that same cycle if the input register is full, so no beat is lost.
// A synchronous reset (rst_n low) parks the car at floor 0 with the door shut,
// clears all requests, leaves maintenance and loads the door and travel limits
// with 3000 and 1000 passes. The user must change the limits through cfg_we, cfg_index
// and cfg_wdata only while no beat is in flight; the block does not enforce this.
`default_nettype none
`include "elevator_car_controller_top_defines.svh"

module elevator_car_controller_top
  import ecc_pkg::*;
#(
  parameter int NUM_FLOORS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  input  wire ecc_in_t              in_data,
  output logic                      in_stall,
  output logic                      out_valid,
  output ecc_out_t                  out_data,
  input  wire logic                 out_stall
);

  logic     s1_valid;
  ecc_in_t  s1_data;
  logic     out_free;
  logic     step_en;
  ecc_out_t result_nxt;
  logic     out_valid_r;
  logic     out_valid_nxt;
  ecc_out_t out_data_r;
  logic     fault_beat;

  // The result register can take a new beat when it is empty or being drained.
  assign out_free      = !out_valid_r || !out_stall;
  assign step_en       = s1_valid && out_free;
  assign out_valid_nxt = step_en || (out_valid_r && out_stall);

  ecc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .advance  (step_en),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  ecc_state #(
    .NUM_FLOORS (NUM_FLOORS)
  ) u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .step_en    (step_en),
    .item       (s1_data),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign fault_beat = out_valid_r && out_data_r.under_maintenance;

  `ECC_ASSERT_NEXT(a_pass_gives_result, step_en, out_valid_r, "pass taken but no result held")
  `ECC_ASSERT_NOW(a_no_pub_in_fault, fault_beat, !out_data_r.status_publish, "publish in fault")
  `ECC_ASSERT_NEXT(a_held_beat_kept, s1_valid && !step_en, s1_valid, "input beat dropped")

endmodule

`default_nettype wire
